@@ rtl/sdspi_pkg.sv @@
// Shared types, constants and frame-byte function for the SD SPI command engine.
// No dependencies; imported by sdspi_core and the top level.

package sdspi_pkg;

	localparam int unsigned R1_POLL_LIMIT = 20;
	localparam int unsigned EXTRA_MAX     = 4;

	localparam logic [7:0] BYTE_IDLE   = 8'hFF;
	localparam logic [7:0] CMD_START   = 8'h40;
	localparam logic [7:0] CRC_CMD0    = 8'h95;
	localparam logic [7:0] CRC_CMD8    = 8'h87;
	localparam logic [7:0] CRC_DEFAULT = 8'h01;
	localparam logic [7:0] R1_BUSY_BIT = 8'h80;

	localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
	localparam logic [5:0] CMD_IF_COND  = 6'd8;

	localparam logic [2:0] FRAME_LEN    = 3'd6;

	localparam logic OP_START = 1'b0;
	localparam logic OP_MISO  = 1'b1;

	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 32;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_READY = 6'b000010,
		PH_FRAME = 6'b000100,
		PH_R1    = 6'b001000,
		PH_EXTRA = 6'b010000,
		PH_TRAIL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        opcode;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic [2:0]  extra_count;
		logic        keep_select;
		logic [7:0]  miso_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       exchange;
		logic       select_n;
		logic       extra_valid;
		logic [7:0] extra_byte;
		logic       done_res;
		logic [7:0] r1_response;
		logic       status;
	} result_t;

	function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [5:0] cmd,
			input logic [31:0] arg);
		logic [7:0] b;
		case (idx)
			3'd0: b = CMD_START | {2'b00, cmd};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				if (cmd == CMD_GO_IDLE) b = CRC_CMD0;
				else if (cmd == CMD_IF_COND) b = CRC_CMD8;
				else b = CRC_DEFAULT;
			end
		endcase
		return b;
	endfunction

endpackage

@@ rtl/sdspi_core.sv @@
// Transaction state and single-pass next-state/result logic, one word per step.
// Depends on sdspi_pkg.

module sdspi_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  sdspi_pkg::item_t   item,
	input  logic [15:0]        ready_poll_limit,
	output sdspi_pkg::result_t res
);
	import sdspi_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  frame_index_q, frame_index_d;
	logic [15:0] poll_count_q, poll_count_d;
	logic [5:0]  saved_cmd_q, saved_cmd_d;
	logic [31:0] saved_arg_q, saved_arg_d;
	logic [2:0]  extra_left_q, extra_left_d;
	logic        saved_keep_q, saved_keep_d;
	logic [7:0]  r1_latch_q, r1_latch_d;

	logic [2:0]  frame_next;
	logic [2:0]  extra_dec;
	logic        r1_end;

	// Hand over the result of R1/extra bytes: finish now or clock one trailing byte.
	function automatic result_t finish_res(input logic keep, input logic xv,
			input logic [7:0] xb, input logic [7:0] r1);
		result_t r;
		r = '0;
		r.extra_valid = xv;
		r.extra_byte  = xb;
		if (keep) begin
			r.done_res    = 1'b1;
			r.r1_response = r1;
		end else begin
			r.mosi_byte = BYTE_IDLE;
			r.exchange  = 1'b1;
			r.select_n  = 1'b1;
		end
		return r;
	endfunction

	assign frame_next = frame_index_q + 3'd1;
	assign extra_dec  = (extra_left_q != 3'd0) ? extra_left_q - 3'd1 : 3'd0;
	assign r1_end     = ((item.miso_byte & R1_BUSY_BIT) == 8'h00)
		|| (poll_count_q >= 16'(R1_POLL_LIMIT));

	always_comb begin
		phase_d       = phase_q;
		frame_index_d = frame_index_q;
		poll_count_d  = poll_count_q;
		saved_cmd_d   = saved_cmd_q;
		saved_arg_d   = saved_arg_q;
		extra_left_d  = extra_left_q;
		saved_keep_d  = saved_keep_q;
		r1_latch_d    = r1_latch_q;
		res           = '0;
		if (item.opcode == OP_START) begin
			saved_cmd_d   = item.cmd_index;
			saved_arg_d   = item.argument;
			extra_left_d  = (item.extra_count > 3'(EXTRA_MAX)) ? 3'(EXTRA_MAX)
				: item.extra_count;
			saved_keep_d  = item.keep_select;
			frame_index_d = 3'd0;
			res.exchange  = 1'b1;
			if (item.cmd_index != CMD_GO_IDLE) begin
				phase_d       = PH_READY;
				poll_count_d  = 16'd1;
				res.mosi_byte = BYTE_IDLE;
			end else begin
				phase_d       = PH_FRAME;
				res.mosi_byte = frame_byte(3'd0, item.cmd_index, item.argument);
			end
		end else begin
			case (phase_q)
				PH_READY: begin
					if (item.miso_byte == BYTE_IDLE) begin
						phase_d       = PH_FRAME;
						frame_index_d = 3'd0;
						res.exchange  = 1'b1;
						res.mosi_byte = frame_byte(3'd0, saved_cmd_q, saved_arg_q);
					end else if (poll_count_q >= ready_poll_limit) begin
						// Card never became ready: release select regardless of keep.
						phase_d         = PH_IDLE;
						saved_keep_d    = 1'b0;
						r1_latch_d      = BYTE_IDLE;
						res.select_n    = 1'b1;
						res.done_res    = 1'b1;
						res.r1_response = BYTE_IDLE;
						res.status      = 1'b1;
					end else begin
						poll_count_d  = poll_count_q + 16'd1;
						res.exchange  = 1'b1;
						res.mosi_byte = BYTE_IDLE;
					end
				end
				PH_FRAME: begin
					frame_index_d = frame_next;
					res.exchange  = 1'b1;
					if (frame_next < FRAME_LEN) begin
						res.mosi_byte = frame_byte(frame_next, saved_cmd_q, saved_arg_q);
					end else begin
						phase_d       = PH_R1;
						poll_count_d  = 16'd1;
						res.mosi_byte = BYTE_IDLE;
					end
				end
				PH_R1: begin
					r1_latch_d = item.miso_byte;
					if (r1_end) begin
						if (extra_left_q != 3'd0) begin
							phase_d       = PH_EXTRA;
							res.exchange  = 1'b1;
							res.mosi_byte = BYTE_IDLE;
						end else begin
							phase_d = saved_keep_q ? PH_IDLE : PH_TRAIL;
							res     = finish_res(saved_keep_q, 1'b0, 8'h00, item.miso_byte);
						end
					end else begin
						poll_count_d  = poll_count_q + 16'd1;
						res.exchange  = 1'b1;
						res.mosi_byte = BYTE_IDLE;
					end
				end
				PH_EXTRA: begin
					extra_left_d = extra_dec;
					if (extra_dec != 3'd0) begin
						res.exchange    = 1'b1;
						res.mosi_byte   = BYTE_IDLE;
						res.extra_valid = 1'b1;
						res.extra_byte  = item.miso_byte;
					end else begin
						phase_d = saved_keep_q ? PH_IDLE : PH_TRAIL;
						res     = finish_res(saved_keep_q, 1'b1, item.miso_byte, r1_latch_q);
					end
				end
				PH_TRAIL: begin
					phase_d         = PH_IDLE;
					res.select_n    = 1'b1;
					res.done_res    = 1'b1;
					res.r1_response = r1_latch_q;
				end
				default: begin
					// Drop stray bytes while idle; select follows the last keep.
					phase_d      = PH_IDLE;
					res.select_n = ~saved_keep_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			frame_index_q <= 3'd0;
			poll_count_q  <= 16'd0;
			saved_cmd_q   <= 6'd0;
			saved_arg_q   <= 32'd0;
			extra_left_q  <= 3'd0;
			saved_keep_q  <= 1'b0;
			r1_latch_q    <= BYTE_IDLE;
		end else if (step) begin
			phase_q       <= phase_d;
			frame_index_q <= frame_index_d;
			poll_count_q  <= poll_count_d;
			saved_cmd_q   <= saved_cmd_d;
			saved_arg_q   <= saved_arg_d;
			extra_left_q  <= extra_left_d;
			saved_keep_q  <= saved_keep_d;
			r1_latch_q    <= r1_latch_d;
		end
	end

	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.opcode == OP_START |=> phase_q == PH_READY || phase_q == PH_FRAME)
		else $error("start word did not enter ready or frame phase");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FRAME |-> frame_index_q < FRAME_LEN)
		else $error("frame index past end of command frame");

	a_extra_sat: assert property (@(posedge clk) disable iff (!arst_n)
		extra_left_q <= 3'(EXTRA_MAX))
		else $error("extra byte count above limit");

	a_done_no_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.exchange && !res.extra_valid || !res.exchange)
		else $error("done reported together with an exchange request");

	a_timeout_release: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.status |=> phase_q == PH_IDLE && !saved_keep_q && r1_latch_q == BYTE_IDLE)
		else $error("ready timeout left select held");

endmodule

@@ rtl/sd_spi_command_transaction_top.sv @@
// Top level: stream ports, input stage, config register and output register.
// Depends on sdspi_pkg and sdspi_core.

// SD SPI-mode command engine. Each input word (a start request or the MISO byte of
// the previous exchange) produces exactly one result word telling the host what to
// clock next, whether select is held, and when the command is done with its R1.
// One word is taken per clock when the output side keeps up; a word's result is
// offered on the master side once it has passed the input stage and then the output
// register, the rate being set by the single next-state pass of the transaction
// state in sdspi_core. ready_poll_limit is written through cfg_we/cfg_wdata; the user
// must write it only while no command is running, as the block does not enforce it.
module sd_spi_command_transaction_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // ready_poll_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd_index[5:0], argument[37:6], extra_count[40:38], keep_select[41],
	// miso_byte[49:42], zero[55:50]
	input  logic [sdspi_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [0:0]  s_tuser,     // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	// mosi_byte[7:0], exchange[8], select_n[9], extra_valid[10], extra_byte[18:11],
	// done_res[19], r1_response[27:20], status[28], zero[31:29]
	output logic [sdspi_pkg::OUT_DATA_W-1:0] m_tdata
);
	import sdspi_pkg::*;

	logic        in_valid_s1;
	item_t       in_item_s1;
	logic [15:0] ready_poll_limit_q;
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic        out_free;
	logic        step;
	result_t     res;
	item_t       in_item;

	// opcode, cmd_index, argument, extra_count, keep_select, miso_byte
	assign in_item = {s_tuser[0], s_tdata[5:0], s_tdata[37:6], s_tdata[40:38],
		s_tdata[41], s_tdata[49:42]};

	assign out_free = !out_valid_q || m_tready;
	assign step     = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_poll_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			ready_poll_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_item_s1 <= in_item;
		end
	end

	sdspi_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.item             (in_item_s1),
		.ready_poll_limit (ready_poll_limit_q),
		.res              (res)
	);

	// Hold the result until taken; load the next one in the same cycle it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {3'b000, res.status, res.r1_response, res.done_res,
				res.extra_byte, res.extra_valid, res.select_n, res.exchange,
				res.mosi_byte};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
